// ===== rtl/smi_pkg.sv =====
// Shared constants for the small matrix inverse core: word format defaults,
// matrix order codes and derived widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smi_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Matrix order codes carried in the input tuser field
  localparam logic [1:0] ORD_NONE = 2'd0;
  localparam logic [1:0] ORD_1    = 2'd1;
  localparam logic [1:0] ORD_2    = 2'd2;
  localparam logic [1:0] ORD_3    = 2'd3;

  localparam int unsigned N_ENT     = 9;
  localparam int unsigned FRONT_LAT = 4;

  // Cofactor: difference of two word products
  function automatic int unsigned cof_bits(input int unsigned w);
    return 2 * w + 1;
  endfunction

  // Determinant: sum of three word-by-cofactor products
  function automatic int unsigned det_bits(input int unsigned w);
    return 3 * w + 3;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/smi_front.sv =====
// Front pipeline: 2x2 minors, cofactor selection by order and exact determinant.
// Four register stages. Depends on smi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smi_front #(
  parameter int unsigned WORD_BITS = smi_pkg::WORD_BITS_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           en,
  input  wire logic [1:0]                                     in_order,
  input  wire logic signed [WORD_BITS-1:0]                    a [smi_pkg::N_ENT],
  output logic [1:0]                                          order_o,
  output logic signed [smi_pkg::cof_bits(WORD_BITS)-1:0]      cof_o [smi_pkg::N_ENT],
  output logic signed [smi_pkg::det_bits(WORD_BITS)-1:0]      det_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned CW = smi_pkg::cof_bits(WORD_BITS);
  localparam int unsigned DW = smi_pkg::det_bits(WORD_BITS);
  localparam int unsigned NE = smi_pkg::N_ENT;

  // cofactor k = a[p]*a[q] - a[r]*a[s]
  localparam int unsigned MI [0:8][0:3] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // stage 1
  logic signed [2*W-1:0] prod0_r [NE];
  logic signed [2*W-1:0] prod1_r [NE];
  logic signed [W-1:0]   a1_r [NE];
  logic [1:0]            ord1_r;
  // stage 2
  logic signed [CW-1:0]  cof2_nxt [NE];
  logic signed [CW-1:0]  cof2_r [NE];
  logic signed [DW-1:0]  det2_nxt;
  logic signed [DW-1:0]  det2_r;
  logic signed [W-1:0]   a2_r [3];
  logic [1:0]            ord2_r;
  // stage 3
  logic signed [2*W:0]   plo_r [3];
  logic signed [2*W:0]   phi_r [3];
  logic signed [CW-1:0]  cof3_r [NE];
  logic signed [DW-1:0]  det3_r;
  logic [1:0]            ord3_r;
  // stage 4
  logic signed [DW-1:0]  hsum;
  logic signed [DW-1:0]  lsum;
  logic signed [DW-1:0]  det4_nxt;
  logic signed [CW-1:0]  cof4_r [NE];
  logic signed [DW-1:0]  det4_r;
  logic [1:0]            ord4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        prod0_r[k] <= a[MI[k][0]] * a[MI[k][1]];
        prod1_r[k] <= a[MI[k][2]] * a[MI[k][3]];
        a1_r[k]    <= a[k];
      end
      ord1_r <= in_order;
    end
  end

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      cof2_nxt[k] = '0;
    end
    det2_nxt = '0;
    case (ord1_r)
      smi_pkg::ORD_1: begin
        cof2_nxt[0] = CW'(1);
        det2_nxt    = DW'(a1_r[0]);
      end
      smi_pkg::ORD_2: begin
        cof2_nxt[0] = CW'(a1_r[4]);
        cof2_nxt[1] = -CW'(a1_r[1]);
        cof2_nxt[3] = -CW'(a1_r[3]);
        cof2_nxt[4] = CW'(a1_r[0]);
        det2_nxt    = DW'(prod0_r[8]) - DW'(prod1_r[8]);
      end
      smi_pkg::ORD_3: begin
        for (int k = 0; k < NE; k++) begin
          cof2_nxt[k] = CW'(prod0_r[k]) - CW'(prod1_r[k]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cof2_r <= cof2_nxt;
      det2_r <= det2_nxt;
      for (int j = 0; j < 3; j++) begin
        a2_r[j] <= a1_r[j];
      end
      ord2_r <= ord1_r;
    end
  end

  // split cofactors 0, 3 and 6 into a low word and a signed high part
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo_r[j] <= a2_r[j] * $signed({1'b0, cof2_r[3*j][W-1:0]});
        phi_r[j] <= a2_r[j] * $signed(cof2_r[3*j][CW-1:W]);
      end
      cof3_r <= cof2_r;
      det3_r <= det2_r;
      ord3_r <= ord2_r;
    end
  end

  always_comb begin
    hsum = DW'(phi_r[0]) + DW'(phi_r[1]) + DW'(phi_r[2]);
    lsum = DW'(plo_r[0]) + DW'(plo_r[1]) + DW'(plo_r[2]);
    if (ord3_r == smi_pkg::ORD_3) begin
      det4_nxt = (hsum <<< W) + lsum;
    end else begin
      det4_nxt = det3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cof4_r <= cof3_r;
      det4_r <= det4_nxt;
      ord4_r <= ord3_r;
    end
  end

  assign cof_o   = cof4_r;
  assign det_o   = det4_r;
  assign order_o = ord4_r;

endmodule

`default_nettype wire

// ===== rtl/smi_div_lane.sv =====
// One divider lane: (cofactor << 2*FRAC_BITS) / determinant, truncated toward
// zero and saturated to a word. Restoring, one quotient bit per stage. Depends on smi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smi_div_lane #(
  parameter int unsigned WORD_BITS = smi_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          en,
  input  wire logic signed [smi_pkg::cof_bits(WORD_BITS)-1:0] cof,
  input  wire logic signed [smi_pkg::det_bits(WORD_BITS)-1:0] det,
  output logic signed [WORD_BITS-1:0]                        quo
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned CW = smi_pkg::cof_bits(WORD_BITS);
  localparam int unsigned DW = smi_pkg::det_bits(WORD_BITS);
  localparam int unsigned NB = 2 * W + 2 * FRAC_BITS;
  localparam int unsigned RW = ((NB > DW + W) ? NB : (DW + W)) + 1;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [CW-1:0] cmag;
  logic [DW-1:0] dmag;
  logic [RW-1:0] num_a_r;
  logic [DW-1:0] d_a_r;
  logic          neg_a_r;

  logic [RW-1:0] rem_r [0:W];
  logic [W-1:0]  q_r   [0:W];
  logic [DW-1:0] d_r   [0:W];
  logic          neg_r [0:W];
  logic          ovf_r [0:W];

  logic [W-1:0]  quo_nxt;
  logic [W-1:0]  quo_r;

  assign cmag = cof[CW-1] ? CW'(-cof) : CW'(cof);
  assign dmag = det[DW-1] ? DW'(-det) : DW'(det);

  always_ff @(posedge clk) begin
    if (en) begin
      num_a_r <= RW'(cmag) << (2 * FRAC_BITS);
      d_a_r   <= dmag;
      neg_a_r <= cof[CW-1] ^ det[DW-1];
    end
  end

  // quotient of more than W bits flags overflow and saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_a_r;
      q_r[0]   <= '0;
      d_r[0]   <= d_a_r;
      neg_r[0] <= neg_a_r;
      ovf_r[0] <= num_a_r >= (RW'(d_a_r) << W);
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_bit
    localparam int unsigned BP = W - 1 - i;
    logic [RW-1:0] dsh;
    logic          ge;

    assign dsh = RW'(d_r[i]) << BP;
    assign ge  = rem_r[i] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? (rem_r[i] - dsh) : rem_r[i];
        q_r[i+1]   <= q_r[i] | (W'(ge) << BP);
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
    end
  end

  always_comb begin
    if (!neg_r[W]) begin
      quo_nxt = (ovf_r[W] || q_r[W][W-1]) ? WMAX : q_r[W];
    end else if (ovf_r[W] || (q_r[W] > WMIN)) begin
      quo_nxt = WMIN;
    end else begin
      quo_nxt = W'(0) - q_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = $signed(quo_r);

endmodule

`default_nettype wire

// ===== rtl/small_matrix_inverse_core.sv =====
// Top level of the small matrix inverse core: front pipeline, nine divider
// lanes, merge stage and output skid. Depends on smi_pkg, smi_front, smi_div_lane.
//
// Usage:
//   Input beat: in_tuser = matrix order (1, 2 or 3), in_tdata = a_00..a_22 in
//   signed Q(WORD_BITS-FRAC_BITS).FRAC_BITS. Output beat: out_tdata = inverse
//   entries inv_00..inv_22 then det_value, out_tuser = singular flag.
//   Throughput: one beat per cycle while the skid entry is empty. Every stage
//   is a register stage; the nine divider lanes run in parallel, each a chain
//   of WORD_BITS one-bit restoring stages, and those chains set the depth.
//   Depth: 4 front stages, WORD_BITS + 3 lane stages, 1 output register.
//   Order 2 ignores entries outside the top-left 2x2; unused results are zero.
//   A zero determinant (or order 0) sets singular and zeroes all other fields.
//   Overflowing results saturate.
//   Stall: the output register plus one skid entry hold results while
//   out_tready is low; the pipeline freezes only once the skid entry fills,
//   and in_tready drops in that same cycle.
//   Reset: synchronous active-low rst_n empties the pipeline and the output.
`timescale 1ns / 1ps
`default_nettype none

module small_matrix_inverse_core #(
  parameter int unsigned WORD_BITS = smi_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       in_tvalid,
  output logic                                            in_tready,
  // a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22 (lowest first), zero pad
  input  wire logic [((9*WORD_BITS+7)/8)*8-1:0]           in_tdata,
  // order
  input  wire logic [1:0]                                 in_tuser,
  output logic                                            out_tvalid,
  input  wire logic                                       out_tready,
  // inv_00 .. inv_22, det_value (lowest first), zero pad
  output logic [((10*WORD_BITS+7)/8)*8-1:0]               out_tdata,
  // singular
  output logic                                            out_tuser
);

  localparam int unsigned W        = WORD_BITS;
  localparam int unsigned CW       = smi_pkg::cof_bits(WORD_BITS);
  localparam int unsigned DW       = smi_pkg::det_bits(WORD_BITS);
  localparam int unsigned NE       = smi_pkg::N_ENT;
  localparam int unsigned LANE_LAT = WORD_BITS + 3;
  localparam int unsigned TOT      = smi_pkg::FRONT_LAT + LANE_LAT;
  localparam int unsigned ODW      = ((10 * WORD_BITS + 7) / 8) * 8;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic                  en;
  logic                  in_fire;
  logic [TOT-1:0]        vld_r;
  logic signed [W-1:0]   a_in [NE];
  logic [1:0]            f_order;
  logic signed [CW-1:0]  f_cof [NE];
  logic signed [DW-1:0]  f_det;
  logic signed [W-1:0]   quo [NE];

  logic [DW-1:0]         dmag;
  logic [DW-1:0]         dsh;
  logic [DW-1:0]         dneg;
  logic [W-1:0]          detv_nxt;
  logic                  sing_nxt;
  logic [W-1:0]          dv_r [LANE_LAT];
  logic                  sg_r [LANE_LAT];

  logic                  push;
  logic [ODW-1:0]        pl_data;
  logic                  pl_sing;
  logic                  out_valid_r;
  logic [ODW-1:0]        out_data_r;
  logic                  out_sing_r;
  logic                  skid_valid_r;
  logic [ODW-1:0]        skid_data_r;
  logic                  skid_sing_r;
  logic                  pop;

  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign in_fire   = in_tvalid && en;

  for (genvar k = 0; k < NE; k++) begin : g_unpack
    assign a_in[k] = $signed(in_tdata[k*W +: W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_fire};
    end
  end

  smi_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk      (clk),
    .en       (en),
    .in_order (in_tuser),
    .a        (a_in),
    .order_o  (f_order),
    .cof_o    (f_cof),
    .det_o    (f_det)
  );

  for (genvar k = 0; k < NE; k++) begin : g_lane
    smi_div_lane #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .cof (f_cof[k]),
      .det (f_det),
      .quo (quo[k])
    );
  end

  // determinant word: drop (order-1)*FRAC_BITS bits toward zero, saturate
  always_comb begin
    dmag = f_det[DW-1] ? DW'(-f_det) : DW'(f_det);
    case (f_order)
      smi_pkg::ORD_2: dsh = dmag >> FRAC_BITS;
      smi_pkg::ORD_3: dsh = dmag >> (2 * FRAC_BITS);
      default:        dsh = dmag;
    endcase
    dneg     = DW'(0) - dsh;
    sing_nxt = (f_det == '0);
    if (sing_nxt) begin
      detv_nxt = '0;
    end else if (!f_det[DW-1]) begin
      detv_nxt = (dsh > DW'(WMAX)) ? WMAX : dsh[W-1:0];
    end else begin
      detv_nxt = (dsh > DW'(WMIN)) ? WMIN : dneg[W-1:0];
    end
  end

  // hold the determinant word beside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= detv_nxt;
      sg_r[0] <= sing_nxt;
      for (int i = 1; i < LANE_LAT; i++) begin
        dv_r[i] <= dv_r[i-1];
        sg_r[i] <= sg_r[i-1];
      end
    end
  end

  // merge lanes into one result beat
  always_comb begin
    pl_data = '0;
    pl_sing = sg_r[LANE_LAT-1];
    for (int k = 0; k < NE; k++) begin
      pl_data[k*W +: W] = pl_sing ? '0 : quo[k];
    end
    pl_data[NE*W +: W] = dv_r[LANE_LAT-1];
  end

  assign push = en && vld_r[TOT-1];
  assign pop  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        out_sing_r   <= skid_sing_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
        out_data_r  <= pl_data;
        out_sing_r  <= pl_sing;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= pl_data;
        skid_sing_r  <= pl_sing;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sing_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_stall_keeps_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_tready) |=> skid_valid_r)
    else $error("skid entry dropped while output stalled");

  a_sing_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sing_r) |-> (out_data_r[NE*W +: W] == '0))
    else $error("singular result with nonzero determinant");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !pop) |=> ($stable(skid_data_r) && out_valid_r))
    else $error("skid entry overwritten");

endmodule

`default_nettype wire

// ===== test/small_matrix_inverse_core_tb.sv =====
// Testbench for small_matrix_inverse_core: streams matrices of order 0 to 3 and checks
// determinant, inverse and singular flag against a wide-integer model of the formulas.
// Depends on smi_pkg and the small_matrix_inverse_core RTL.
`timescale 1ns / 1ps

module small_matrix_inverse_core_tb;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int LIMIT_CYCLES = 300000;

  typedef logic signed [199:0] wide_t;
  typedef logic signed [W-1:0] entry_t;
  typedef entry_t mat_t [9];
  // {singular, det_value, inv_22 .. inv_00}
  typedef logic [10*W:0] inv_beat_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [9*W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [10*W-1:0] out_tdata;
  logic out_tuser;

  inv_beat_t expected_q[$];
  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;

  small_matrix_inverse_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic entry_t saturate(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (W - 1)) - 1;
    lo = -(wide_t'(1) <<< (W - 1));
    if (v > hi) return {1'b0, {(W-1){1'b1}}};
    if (v < lo) return {1'b1, {(W-1){1'b0}}};
    return v[W-1:0];
  endfunction

  function automatic inv_beat_t predict_inverse(input logic [1:0] ord, input mat_t a);
    wide_t e[9];
    wide_t c[9];
    wide_t d;
    inv_beat_t r;
    r = '0;
    for (int i = 0; i < 9; i++) begin
      e[i] = a[i];
      c[i] = 0;
    end
    case (ord)
      smi_pkg::ORD_NONE: begin
        r[10*W] = 1'b1;
        return r;
      end
      smi_pkg::ORD_1: begin
        d = e[0];
        c[0] = 1;
      end
      smi_pkg::ORD_2: begin
        d = e[0]*e[4] - e[1]*e[3];
        c[0] = e[4];
        c[1] = -e[1];
        c[3] = -e[3];
        c[4] = e[0];
      end
      default: begin
        c[0] = e[4]*e[8] - e[5]*e[7];
        c[1] = e[2]*e[7] - e[1]*e[8];
        c[2] = e[1]*e[5] - e[2]*e[4];
        c[3] = e[5]*e[6] - e[3]*e[8];
        c[4] = e[0]*e[8] - e[2]*e[6];
        c[5] = e[2]*e[3] - e[0]*e[5];
        c[6] = e[3]*e[7] - e[4]*e[6];
        c[7] = e[1]*e[6] - e[0]*e[7];
        c[8] = e[0]*e[4] - e[1]*e[3];
        d = e[0]*c[0] + e[1]*c[3] + e[2]*c[6];
      end
    endcase
    if (d == 0) begin
      r[10*W] = 1'b1;
      return r;
    end
    // signed division truncates toward zero, as the fixed-point scaling requires
    r[9*W +: W] = saturate(d / (wide_t'(1) <<< ((ord - 1) * FB)));
    for (int i = 0; i < 9; i++)
      r[i*W +: W] = saturate((c[i] <<< (2 * FB)) / d);
    return r;
  endfunction

  // Drive one matrix and hold it until accepted; gaps fall between bursts.
  task automatic send_matrix(input logic [1:0] ord, input mat_t a);
    logic [9*W-1:0] packed_a;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    for (int i = 0; i < 9; i++) packed_a[i*W +: W] = a[i];
    in_tvalid <= 1'b1;
    in_tdata <= packed_a;
    in_tuser <= ord;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(predict_inverse(ord, a));
  endtask

  function automatic entry_t rand_entry(input int mode);
    case (mode)
      0: return entry_t'($urandom);
      1: return entry_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      2: return entry_t'(int'($urandom_range(0, 1 << 8)) - (1 << 7));
      default: begin
        case ($urandom_range(0, 5))
          0: return {1'b1, {(W-1){1'b0}}};
          1: return {1'b0, {(W-1){1'b1}}};
          2: return entry_t'(0);
          3: return entry_t'(1);
          4: return entry_t'(-1);
          default: return entry_t'(32'sh0001_0000);
        endcase
      end
    endcase
  endfunction

  task automatic fill_matrix(output mat_t a, input int mode);
    for (int i = 0; i < 9; i++)
      a[i] = rand_entry(mode == 4 ? $urandom_range(0, 3) : mode);
  endtask

  task automatic test_order_zero();
    mat_t a;
    fill_matrix(a, 0);
    send_matrix(smi_pkg::ORD_NONE, a);
  endtask

  task automatic test_order_one();
    mat_t a;
    entry_t vals[7];
    vals = '{32'sh0001_0000, -32'sh0001_0000, 0, 1, -1,
             {1'b0, {(W-1){1'b1}}}, {1'b1, {(W-1){1'b0}}}};
    foreach (vals[k]) begin
      fill_matrix(a, 0);
      a[0] = vals[k];
      send_matrix(smi_pkg::ORD_1, a);
    end
  endtask

  task automatic test_order_two();
    mat_t a;
    // identity with junk outside the used corner
    fill_matrix(a, 0);
    a[0] = 32'sh0001_0000; a[1] = 0; a[3] = 0; a[4] = 32'sh0001_0000;
    send_matrix(smi_pkg::ORD_2, a);
    // singular: proportional rows
    fill_matrix(a, 0);
    a[0] = 32'sh0002_0000; a[1] = 32'sh0004_0000; a[3] = 32'sh0001_0000;
    a[4] = 32'sh0002_0000;
    send_matrix(smi_pkg::ORD_2, a);
    // all extremes drive the determinant into saturation
    for (int i = 0; i < 9; i++) a[i] = {1'b1, {(W-1){1'b0}}};
    a[1] = {1'b0, {(W-1){1'b1}}};
    send_matrix(smi_pkg::ORD_2, a);
    fill_matrix(a, 2);
    send_matrix(smi_pkg::ORD_2, a);
  endtask

  task automatic test_order_three();
    mat_t a;
    for (int i = 0; i < 9; i++) a[i] = (i % 4 == 0) ? 32'sh0001_0000 : 0;
    send_matrix(smi_pkg::ORD_3, a);
    fill_matrix(a, 1);
    a[6] = a[0]; a[7] = a[1]; a[8] = a[2];
    send_matrix(smi_pkg::ORD_3, a);
    for (int i = 0; i < 9; i++) a[i] = {1'b0, {(W-1){1'b1}}};
    a[4] = {1'b1, {(W-1){1'b0}}};
    send_matrix(smi_pkg::ORD_3, a);
    for (int i = 0; i < 9; i++) a[i] = (i % 4 == 0) ? 1 : 0;
    send_matrix(smi_pkg::ORD_3, a);
    fill_matrix(a, 0);
    send_matrix(smi_pkg::ORD_3, a);
    fill_matrix(a, 1);
    send_matrix(smi_pkg::ORD_3, a);
  endtask

  task automatic test_random(input int count);
    mat_t a;
    logic [1:0] ord;
    for (int n = 0; n < count; n++) begin
      ord = logic'($urandom_range(0, 15) == 0) ? smi_pkg::ORD_NONE
                                               : 2'($urandom_range(1, 3));
      fill_matrix(a, $urandom_range(0, 4));
      // some singular cases: first row duplicated into a later row
      if ($urandom_range(0, 9) == 0) begin
        if (ord == smi_pkg::ORD_3) begin
          a[6] = a[0]; a[7] = a[1]; a[8] = a[2];
        end else begin
          a[3] = a[0]; a[4] = a[1];
        end
      end
      send_matrix(ord, a);
    end
  endtask

  // Receiver: stall style changes every so often, including stretches with no stalls.
  int stall_style = 0;
  int style_left = 0;
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 2);
      style_left <= $urandom_range(20, 200);
    end else begin
      style_left <= style_left - 1;
    end
    if (!rst_n) out_tready <= 1'b0;
    else case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    inv_beat_t exp_beat;
    inv_beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, got);
      end else begin
        exp_beat = expected_q.pop_front();
        for (int f = 0; f < 10; f++)
          if (got[f*W +: W] !== exp_beat[f*W +: W]) begin
            errors++;
            $display("%0t: field %0d expected %h actual %h", $time, f,
                     exp_beat[f*W +: W], got[f*W +: W]);
          end
        if (got[10*W] !== exp_beat[10*W]) begin
          errors++;
          $display("%0t: singular expected %b actual %b", $time, exp_beat[10*W], got[10*W]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL small_matrix_inverse_core");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= smi_pkg::ORD_NONE;
    out_tready <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_order_zero();
    test_order_one();
    test_order_two();
    test_order_three();
    test_random(750);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("PASS small_matrix_inverse_core");
    else
      $display("FAIL small_matrix_inverse_core");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/smi_pkg.sv
rtl/smi_front.sv
rtl/smi_div_lane.sv
rtl/small_matrix_inverse_core.sv
test/small_matrix_inverse_core_tb.sv
